// ===== rtl/build_max_heap_top_defines.svh =====
// assertion macros for the max-heap builder
`ifndef BUILD_MAX_HEAP_TOP_DEFINES_SVH
`define BUILD_MAX_HEAP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BMH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMH_ASSERT(lbl, prop, msg)
`define BMH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/bmh_pkg.sv =====
// shared constants and types for the max-heap builder
`timescale 1ns / 1ps
package bmh_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1) + 1;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        addr_t raddr;
    } mem_req_t;

endpackage

// ===== rtl/bmh_ram.sv =====
// heap storage, one write and one registered read per cycle
`timescale 1ns / 1ps
module bmh_ram (
    input  logic              clk,
    input  bmh_pkg::mem_req_t req,
    output bmh_pkg::data_t    rdata
);
    import bmh_pkg::*;

    data_t mem [MAX_ITEMS];
    data_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bmh_cmp.sv =====
// shared signed less-than compare unit
`timescale 1ns / 1ps
module bmh_cmp (
    input  bmh_pkg::data_t a,
    input  bmh_pkg::data_t b,
    output logic           less
);
    import bmh_pkg::*;

    assign less = ($signed(a) < $signed(b));

endmodule

// ===== rtl/bmh_seq.sv =====
// load, sift-down and emit sequencer
`timescale 1ns / 1ps
`include "build_max_heap_top_defines.svh"
module bmh_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bmh_pkg::data_t    item_value,
    input  logic              last_item,
    output logic              busy,
    input  bmh_pkg::data_t    rdata,
    input  logic              less,
    output bmh_pkg::data_t    cmp_a,
    output bmh_pkg::data_t    cmp_b,
    output bmh_pkg::mem_req_t req,
    output logic              strobe,
    output logic              heap_last,
    output logic              dropped
);
    import bmh_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADV = 3'd1;
    localparam logic [2:0] S_GETV  = 3'd2;
    localparam logic [2:0] S_LEVEL = 3'd3;
    localparam logic [2:0] S_RDL   = 3'd4;
    localparam logic [2:0] S_RDR   = 3'd5;
    localparam logic [2:0] S_CMPV  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0] state_reg, state_next;
    cnt_t       cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;
    cnt_t       n_reg, n_next;
    addr_t      r_reg, r_next;
    cnt_t       pos_reg, pos_next;
    addr_t      cidx_reg, cidx_next;
    addr_t      k_reg, k_next;
    data_t      v_reg, v_next;
    data_t      cval_reg, cval_next;
    logic       strobe_reg, strobe_next;
    logic       last_reg, last_next;
    logic       drop_reg, drop_next;

    cnt_t                 n_new;
    logic [CNT_W:0]       child;
    cnt_t                 cidx_inc;
    logic                 root_done;

    assign n_new     = (cnt_reg < CNT_W'(MAX_ITEMS)) ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign child     = {1'b0, pos_reg} << 1;
    assign cidx_inc  = CNT_W'(cidx_reg) + CNT_W'(1);
    assign root_done = (r_reg == ADDR_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovf_next    = ovf_reg;
        n_next      = n_reg;
        r_next      = r_reg;
        pos_next    = pos_reg;
        cidx_next   = cidx_reg;
        k_next      = k_reg;
        v_next      = v_reg;
        cval_next   = cval_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        drop_next   = drop_reg;
        req.we      = 1'b0;
        req.waddr   = cnt_reg[ADDR_W-1:0];
        req.wdata   = item_value;
        req.raddr   = k_reg;
        cmp_a       = v_reg;
        cmp_b       = cval_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cnt_reg < CNT_W'(MAX_ITEMS))
                    begin
                        req.we   = 1'b1;
                        cnt_next = n_new;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_item)
                    begin
                        n_next = n_new;
                        r_next = ADDR_W'(n_new >> 1);
                        k_next = '0;
                        if ((n_new >> 1) == '0)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_LOADV;
                        end
                    end
                end
            end
            S_LOADV:
            begin
                req.raddr  = r_reg - ADDR_W'(1);
                pos_next   = CNT_W'(r_reg);
                state_next = S_GETV;
            end
            S_GETV:
            begin
                v_next     = rdata;
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                if (child > {1'b0, n_reg})
                begin
                    // leaf reached, settle the held value
                    req.we    = 1'b1;
                    req.waddr = ADDR_W'(pos_reg - CNT_W'(1));
                    req.wdata = v_reg;
                    if (root_done)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        r_next     = r_reg - ADDR_W'(1);
                        state_next = S_LOADV;
                    end
                end
                else
                begin
                    req.raddr  = ADDR_W'(child - (CNT_W + 1)'(1));
                    cidx_next  = ADDR_W'(child - (CNT_W + 1)'(1));
                    state_next = S_RDL;
                end
            end
            S_RDL:
            begin
                cval_next = rdata;
                if (cidx_inc < n_reg)
                begin
                    req.raddr  = ADDR_W'(cidx_inc);
                    state_next = S_RDR;
                end
                else
                begin
                    state_next = S_CMPV;
                end
            end
            S_RDR:
            begin
                cmp_a = cval_reg;
                cmp_b = rdata;
                if (less)
                begin
                    cval_next = rdata;
                    cidx_next = ADDR_W'(cidx_inc);
                end
                state_next = S_CMPV;
            end
            S_CMPV:
            begin
                req.we    = 1'b1;
                req.waddr = ADDR_W'(pos_reg - CNT_W'(1));
                if (less)
                begin
                    req.wdata  = cval_reg;
                    pos_next   = cidx_inc;
                    state_next = S_LEVEL;
                end
                else
                begin
                    req.wdata = v_reg;
                    if (root_done)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        r_next     = r_reg - ADDR_W'(1);
                        state_next = S_LOADV;
                    end
                end
            end
            S_EMIT:
            begin
                req.raddr   = k_reg;
                strobe_next = 1'b1;
                drop_next   = ovf_reg;
                last_next   = (CNT_W'(k_reg) + CNT_W'(1) == n_reg);
                if (last_next)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        r_reg    <= r_next;
        pos_reg  <= pos_next;
        cidx_reg <= cidx_next;
        k_reg    <= k_next;
        v_reg    <= v_next;
        cval_reg <= cval_next;
        last_reg <= last_next;
        drop_reg <= drop_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign heap_last = last_reg;
    assign dropped   = drop_reg;

    `BMH_ASSERT(a_gap_after_last, strobe_reg && last_reg |=> !strobe_reg, "result after final")
    `BMH_ASSERT(a_strobe_from_emit, strobe_reg |-> $past(state_reg == S_EMIT), "stray result")
    `BMH_ASSERT(a_overflow_flag, !busy && start && !last_item && cnt_reg == CNT_W'(MAX_ITEMS) |=> ovf_reg, "overflow lost")
    `BMH_ASSERT_ALWAYS(a_count_range, !rst_n || cnt_reg <= CNT_W'(MAX_ITEMS), "count beyond capacity")

endmodule

// ===== rtl/build_max_heap_top.sv =====
// max-heap builder top level
// loading: one value per cycle, busy stays low between values of a batch
// build: fetch each parent, then per sift level compare its children via the shared compare unit
// emission: n results on consecutive cycles, via the emit state and then the strobe register
// results cannot be stalled; busy is high after the final value and drops as the last result issues
// reset clears the sequencer, fill count and overflow flag; the store itself is not cleared
`timescale 1ns / 1ps
module build_max_heap_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] item_value,
    input  logic               last_item,
    output logic               strobe,
    output logic signed [31:0] heap_value,
    output logic               heap_last,
    output logic               dropped
);
    import bmh_pkg::*;

    mem_req_t req;
    data_t    rdata;
    data_t    cmp_a;
    data_t    cmp_b;
    logic     less;

    bmh_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item_value (item_value),
        .last_item  (last_item),
        .busy       (busy),
        .rdata      (rdata),
        .less       (less),
        .cmp_a      (cmp_a),
        .cmp_b      (cmp_b),
        .req        (req),
        .strobe     (strobe),
        .heap_last  (heap_last),
        .dropped    (dropped)
    );

    bmh_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    bmh_cmp u_cmp (
        .a    (cmp_a),
        .b    (cmp_b),
        .less (less)
    );

    assign heap_value = rdata;

endmodule
